// ===== design/rteq_pkg.sv =====
package rteq_pkg;

  localparam int NUM_EVENTS_DEF = 16;
  localparam int KIND_W = 2;
  localparam int ID_W = 4;

  typedef enum logic [KIND_W-1:0] {
    K_TRIGGER  = 2'd0,
    K_CANCEL   = 2'd1,
    K_DISPATCH = 2'd2,
    K_FINISH   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PENDING = 2'd1,
    ST_EXEC    = 2'd2,
    ST_RETRIG  = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_EXEC,
    C_LINK
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic link;
  } cmd_t;

  typedef struct packed {
    logic imm;
    logic need_link;
    logic out_free;
  } sts_t;

endpackage

// ===== design/rteq_ctrl.sv =====
module rteq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rteq_pkg::sts_t sts,
  output rteq_pkg::cmd_t cmd
);
  import rteq_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       take;

  assign take = (state_r == C_IDLE) && in_valid && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE: begin
        if (take && !sts.imm) state_nxt = C_EXEC;
      end
      C_EXEC: begin
        state_nxt = sts.need_link ? C_LINK : C_IDLE;
      end
      C_LINK: begin
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall   = !((state_r == C_IDLE) && sts.out_free);
    cmd.accept = take;
    cmd.exec   = (state_r == C_EXEC);
    cmd.link   = (state_r == C_LINK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/rteq_dp.sv =====
module rteq_dp #(
  parameter int NUM_EVENTS = rteq_pkg::NUM_EVENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rteq_pkg::KIND_W-1:0] in_kind,
  input  logic [rteq_pkg::ID_W-1:0]   in_event_id,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic                        out_dispatched,
  output logic [rteq_pkg::ID_W-1:0]   out_dispatched_id,
  output logic [1:0]                  out_prior_state,
  output logic                        out_queue_empty,
  input  rteq_pkg::cmd_t              cmd,
  output rteq_pkg::sts_t              sts
);
  import rteq_pkg::*;

  localparam int IDX_W = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int LNK_W = $clog2(NUM_EVENTS + 1);
  localparam logic [LNK_W-1:0] NIL = LNK_W'(NUM_EVENTS);

  slot_state_t      state_mem [NUM_EVENTS];
  logic [LNK_W-1:0] next_mem  [NUM_EVENTS];
  logic [LNK_W-1:0] prev_mem  [NUM_EVENTS];
  logic [NUM_EVENTS-1:0] sv_r;

  kind_t            kind_r;
  logic [LNK_W-1:0] tgt_r;
  logic [LNK_W-1:0] head_r, head_nxt;
  logic [LNK_W-1:0] tail_r, tail_nxt;
  logic [LNK_W-1:0] link_addr_r;

  slot_state_t      st_q;
  logic             sv_q;
  logic [LNK_W-1:0] nx_q, pv_q;

  logic             out_valid_r;
  logic             disp_r;
  logic [ID_W-1:0]  disp_id_r;
  logic [1:0]       prior_r;
  logic             empty_r;

  kind_t            kind_in;
  logic             id_ok;
  logic [LNK_W-1:0] tgt_in;

  slot_state_t      st;
  logic             st_we;
  slot_state_t      st_wd;
  logic             nx_we;
  logic [LNK_W-1:0] nx_wa, nx_wd;
  logic             pv_we;
  logic [LNK_W-1:0] pv_wa, pv_wd;
  logic             need_link;
  logic             disp;
  logic             do_push;
  logic             do_unlink;

  assign kind_in = kind_t'(in_kind);
  assign id_ok   = 32'(in_event_id) < NUM_EVENTS;
  assign tgt_in  = (kind_in == K_DISPATCH) ? head_r : LNK_W'(in_event_id);

  assign sts.imm       = (kind_in == K_DISPATCH) ? (head_r == NIL) : !id_ok;
  assign sts.need_link = need_link;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign st = sv_q ? st_q : ST_IDLE;

  always_comb begin
    do_push   = 1'b0;
    do_unlink = 1'b0;
    disp      = 1'b0;
    st_we     = 1'b0;
    st_wd     = ST_IDLE;
    unique case (kind_r)
      K_DISPATCH: begin
        disp  = 1'b1;
        st_we = 1'b1;
        st_wd = ST_EXEC;
      end
      K_TRIGGER: begin
        if (st == ST_IDLE) begin
          do_push = 1'b1;
        end else if (st == ST_EXEC) begin
          st_we = 1'b1;
          st_wd = ST_RETRIG;
        end
      end
      K_CANCEL: begin
        if (st == ST_PENDING) do_unlink = 1'b1;
      end
      K_FINISH: begin
        if (st == ST_RETRIG) begin
          do_push = 1'b1;
        end else if (st == ST_EXEC) begin
          st_we = 1'b1;
          st_wd = ST_IDLE;
        end
      end
      default: begin
        disp = 1'b0;
      end
    endcase
    if (do_push) begin
      st_we = 1'b1;
      st_wd = ST_PENDING;
    end
    if (do_unlink) begin
      st_we = 1'b1;
      st_wd = ST_IDLE;
    end
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    nx_we     = 1'b0;
    nx_wa     = tgt_r;
    nx_wd     = NIL;
    pv_we     = 1'b0;
    pv_wa     = tgt_r;
    pv_wd     = NIL;
    need_link = 1'b0;
    if (disp) begin
      head_nxt = nx_q;
      if (nx_q != NIL) begin
        pv_we = 1'b1;
        pv_wa = nx_q;
        pv_wd = NIL;
      end else begin
        head_nxt = NIL;
        tail_nxt = NIL;
      end
    end
    if (do_push) begin
      nx_we = 1'b1;
      nx_wa = tgt_r;
      nx_wd = NIL;
      pv_we = 1'b1;
      pv_wa = tgt_r;
      pv_wd = tail_r;
      if ((tail_r != NIL) && (head_r != NIL)) begin
        need_link = 1'b1;
      end else begin
        head_nxt = tgt_r;
      end
      tail_nxt = tgt_r;
    end
    if (do_unlink) begin
      if (tgt_r == head_r) begin
        head_nxt = nx_q;
      end else if (pv_q != NIL) begin
        nx_we = 1'b1;
        nx_wa = pv_q;
        nx_wd = nx_q;
      end
      if (tgt_r == tail_r) begin
        tail_nxt = pv_q;
      end else if (nx_q != NIL) begin
        pv_we = 1'b1;
        pv_wa = nx_q;
        pv_wd = pv_q;
      end
      if (head_nxt == NIL) tail_nxt = NIL;
    end
    if (cmd.link) begin
      nx_we = 1'b1;
      nx_wa = link_addr_r;
      nx_wd = tgt_r;
    end
  end

  // link memories and slot state store
  always_ff @(posedge clk) begin
    if (cmd.accept && !sts.imm) begin
      st_q <= state_mem[tgt_in[IDX_W-1:0]];
      nx_q <= next_mem[tgt_in[IDX_W-1:0]];
      pv_q <= prev_mem[tgt_in[IDX_W-1:0]];
    end
    if (cmd.exec && st_we) state_mem[tgt_r[IDX_W-1:0]] <= st_wd;
    if ((cmd.exec || cmd.link) && nx_we) next_mem[nx_wa[IDX_W-1:0]] <= nx_wd;
    if (cmd.exec && pv_we) prev_mem[pv_wa[IDX_W-1:0]] <= pv_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r        <= '0;
      head_r      <= NIL;
      tail_r      <= NIL;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec && st_we) sv_r[tgt_r[IDX_W-1:0]] <= 1'b1;
      if (cmd.exec) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
      end
      if ((cmd.accept && sts.imm) || cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= kind_in;
      tgt_r  <= tgt_in;
      if (!sts.imm) sv_q <= sv_r[tgt_in[IDX_W-1:0]];
    end
    if (cmd.exec) link_addr_r <= tail_r;
    if (cmd.accept && sts.imm) begin
      disp_r    <= 1'b0;
      disp_id_r <= '0;
      prior_r   <= 2'(ST_IDLE);
      empty_r   <= (head_r == NIL);
    end else if (cmd.exec) begin
      disp_r    <= disp;
      disp_id_r <= disp ? ID_W'(tgt_r) : '0;
      prior_r   <= 2'(st);
      empty_r   <= (head_nxt == NIL);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_dispatched    = disp_r;
  assign out_dispatched_id = disp_id_r;
  assign out_prior_state   = prior_r;
  assign out_queue_empty   = empty_r;

endmodule

// ===== design/retriggerable_event_queue.sv =====
// retriggerable event queue: fifo of pending event slots with re-queue on finish
// input channel in_valid/in_stall carries one transaction of in_kind and
// in_event_id (trigger, cancel, dispatch head, finish); every transaction
// gives exactly one result on out_valid/out_stall: out_dispatched,
// out_dispatched_id, out_prior_state, out_queue_empty
// a dispatch on an empty queue or an id out of range gets its result registered
// straight from the accept; other transactions first read slot state and links
// from the registered-read slot memories, then update them and give the result
// a new transaction is taken only in idle: straight after an immediate case,
// after the update in most cases, or after a further link step for an append
// behind a non-empty queue (a second write on the next-link memory port)
// reset (rst_n low, synchronous): all slots idle, queue empty, no result
// held; the link memories are not cleared
// the result sits in an output register; while the receiver stalls it holds
// and no new transaction is taken until the result is taken
module retriggerable_event_queue #(
  parameter int NUM_EVENTS = rteq_pkg::NUM_EVENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rteq_pkg::KIND_W-1:0] in_kind,
  input  logic [rteq_pkg::ID_W-1:0]   in_event_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_dispatched,
  output logic [rteq_pkg::ID_W-1:0]   out_dispatched_id,
  output logic [1:0]                  out_prior_state,
  output logic                        out_queue_empty
);
  import rteq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rteq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rteq_dp #(
    .NUM_EVENTS (NUM_EVENTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_kind           (in_kind),
    .in_event_id       (in_event_id),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_dispatched    (out_dispatched),
    .out_dispatched_id (out_dispatched_id),
    .out_prior_state   (out_prior_state),
    .out_queue_empty   (out_queue_empty),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
